// File: rtl/wllp_pkg.sv
// ----------------------------------------------------------------------------
// wllp_pkg
// Shared codes and field widths for the windowed least-loaded placer.
// ----------------------------------------------------------------------------
`default_nettype none

package wllp_pkg;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_PLACED   = 2'd0;
  localparam status_t STAT_BAD_HOME = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_NUM_BUCKETS  = 2'd0;
  localparam cfg_idx_t REG_WINDOW_REACH = 2'd1;

  // Fixed field widths
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned NB_W       = 7;
  localparam int unsigned REACH_W    = 6;
  localparam int unsigned HOME_W     = 16;
  localparam int unsigned CHOSEN_W   = 6;
  localparam int unsigned FILL_OUT_W = 16;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned WASTE_W    = 22;

  // Power-on value of the bucket count register
  localparam logic [NB_W-1:0] NB_RESET = 7'd64;

endpackage

`default_nettype wire

// File: rtl/windowed_least_loaded_placer.sv
// ----------------------------------------------------------------------------
// windowed_least_loaded_placer
// Places each item in the least-filled bucket within a window around its
// home bucket; keeps bucket fills in a synchronous RAM and running totals.
// ----------------------------------------------------------------------------
//  channel   ports                              transaction
//  input     start, busy, in_home_bucket        start & !busy at rising edge
//  result    out_valid, out_*                   one-cycle strobe, no backpressure
//  config    cfg_we, cfg_index, cfg_wdata       cfg_we at rising edge
//
//  A valid item goes from accept through S_SCAN, S_DRAIN, S_DECIDE, S_CALC
//  and S_OUT to the strobe: the RAM is read once per cycle over the window,
//  then one write-back and a multiply stage for the waste total. An
//  out-of-range item goes through S_CALC and S_OUT only. After reset the
//  fill RAM is cleared, one entry a cycle over all MAX_BUCKETS entries, with
//  busy high. Writing num_buckets starts a sum sweep over the buckets in use,
//  busy high. Results cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_least_loaded_placer
  import wllp_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 64,
  parameter int unsigned FILL_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command input
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [HOME_W-1:0]     in_home_bucket,
  // results
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [CHOSEN_W-1:0]        out_chosen_bucket,
  output logic [FILL_OUT_W-1:0]      out_new_fill,
  output logic [FILL_OUT_W-1:0]      out_highest_fill,
  output logic [COUNT_W-1:0]         out_valid_total,
  output logic [COUNT_W-1:0]         out_invalid_total,
  output logic [WASTE_W-1:0]         out_wasted_total,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Derived widths
  localparam int unsigned AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW    = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned FB    = FILL_BITS;
  localparam int unsigned CMPW  = (NW > NB_W) ? NW : NB_W;
  localparam int unsigned SW    = ((AW > REACH_W) ? AW : REACH_W) + 1;
  localparam int unsigned PW    = NW + FB;
  localparam int unsigned XW    = (PW > WASTE_W) ? PW : WASTE_W;
  localparam logic [FB-1:0] FILL_CAP  = {FB{1'b1}};
  localparam logic [XW-1:0] WASTE_MAX = XW'({WASTE_W{1'b1}});

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_CALC   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [NB_W-1:0]    nb_r;
  logic [REACH_W-1:0] reach_r;
  logic               sweep_pend_r;
  logic               sweep_mode_r;

  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [REACH_W-1:0] d_r, d_nxt;
  logic               side_r, side_nxt;
  logic [AW-1:0]      home_r;

  logic [FB-1:0]      mem [MAX_BUCKETS];
  logic [FB-1:0]      rd_data_r;
  logic               rd_ok_r;
  logic               rd_first_r;
  logic [AW-1:0]      rd_addr_r;

  logic [AW-1:0]      best_r;
  logic [FB-1:0]      best_fill_r;
  logic [FB-1:0]      peak_r;
  logic [PW-1:0]      sum_r;
  logic [PW-1:0]      prod_r;
  logic [COUNT_W-1:0] valid_cnt_r, invalid_cnt_r;

  logic [1:0]         res_status_r;
  logic [AW-1:0]      res_chosen_r;
  logic [FB-1:0]      res_fill_r;

  // Buckets in use: register value capped at the built size
  logic [CMPW-1:0] nb_ext;
  logic [NW-1:0]   n_used;
  assign nb_ext = CMPW'(nb_r);
  assign n_used = (nb_ext > CMPW'(MAX_BUCKETS)) ? NW'(MAX_BUCKETS) : NW'(nb_ext);

  // Home range check on the raw input
  logic home_ok;
  assign home_ok = !in_home_bucket[HOME_W-1] &&
                   (in_home_bucket < HOME_W'(n_used));

  logic accept;
  assign busy   = (state_r != S_IDLE) || sweep_pend_r;
  assign accept = start && !busy;

  // Window scan address: home, then left/right at growing distance
  logic [SW-1:0] right_sum;
  logic          issue_ok, issue_last, issuing;
  logic [AW-1:0] raddr;
  assign right_sum = SW'(home_r) + SW'(d_r);

  always_comb begin
    issue_ok   = 1'b0;
    issue_last = 1'b0;
    issuing    = 1'b0;
    raddr      = cnt_r;
    unique case (state_r)
      S_SWEEP: begin
        issuing    = 1'b1;
        issue_ok   = (n_used != '0);
        issue_last = (n_used == '0) || ((NW'(cnt_r) + NW'(1)) == n_used);
        raddr      = cnt_r;
      end
      S_SCAN: begin
        issuing    = 1'b1;
        issue_last = (d_r == reach_r) && ((d_r == '0) || side_r);
        if (d_r == '0) begin
          issue_ok = 1'b1;
          raddr    = home_r;
        end else if (!side_r) begin
          issue_ok = SW'(d_r) <= SW'(home_r);
          raddr    = AW'(SW'(home_r) - SW'(d_r));
        end else begin
          issue_ok = right_sum < SW'(n_used);
          raddr    = AW'(right_sum);
        end
      end
      default: begin
      end
    endcase
  end

  // Write-back port: clearing pass or placement
  logic          full;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [FB-1:0] mem_wdata;
  logic [FB-1:0] fill_inc;
  assign full     = (best_fill_r == FILL_CAP);
  assign fill_inc = best_fill_r + FB'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if ((state_r == S_DECIDE) && !full) begin
      mem_we    = 1'b1;
      mem_waddr = best_r;
      mem_wdata = fill_inc;
    end
  end

  // Fill RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // Next-state and counter logic
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    d_nxt     = d_r;
    side_nxt  = side_r;
    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        d_nxt   = '0;
        side_nxt = 1'b0;
        priority if (sweep_pend_r) begin
          state_nxt = S_SWEEP;
        end else if (accept) begin
          state_nxt = home_ok ? S_SCAN : S_CALC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + AW'(1);
        if (issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_SCAN: begin
        if (d_r == '0) begin
          d_nxt    = REACH_W'(1);
          side_nxt = 1'b0;
        end else if (!side_r) begin
          side_nxt = 1'b1;
        end else begin
          d_nxt    = d_r + REACH_W'(1);
          side_nxt = 1'b0;
        end
        if (issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = sweep_mode_r ? S_IDLE : S_DECIDE;
      S_DECIDE: state_nxt = S_CALC;
      S_CALC:   state_nxt = S_OUT;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Waste from n*peak minus the sum of fills in use, saturated
  logic [PW-1:0] diff;
  logic [XW-1:0] diff_ext;
  logic [WASTE_W-1:0] waste;
  assign diff     = prod_r - sum_r;
  assign diff_ext = XW'(diff);
  assign waste    = (diff_ext > WASTE_MAX) ? WASTE_W'(WASTE_MAX) : WASTE_W'(diff_ext);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      cnt_r         <= '0;
      d_r           <= '0;
      side_r        <= 1'b0;
      nb_r          <= NB_RESET;
      reach_r       <= '0;
      sweep_pend_r  <= 1'b0;
      sweep_mode_r  <= 1'b0;
      rd_ok_r       <= 1'b0;
      peak_r        <= '0;
      sum_r         <= '0;
      valid_cnt_r   <= '0;
      invalid_cnt_r <= '0;
      out_valid     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      d_r       <= d_nxt;
      side_r    <= side_nxt;
      rd_ok_r   <= issuing && issue_ok;
      out_valid <= (state_r == S_OUT);

      // configuration writes
      if (cfg_we) begin
        if (cfg_index == REG_NUM_BUCKETS) begin
          nb_r <= cfg_wdata[NB_W-1:0];
        end else if (cfg_index == REG_WINDOW_REACH) begin
          reach_r <= cfg_wdata[REACH_W-1:0];
        end
      end

      // a new bucket count needs a fresh fill sum; taken when idle
      if (cfg_we && (cfg_index == REG_NUM_BUCKETS)) begin
        sweep_pend_r <= 1'b1;
      end else if ((state_r == S_IDLE) && sweep_pend_r) begin
        sweep_pend_r <= 1'b0;
      end

      if ((state_r == S_IDLE) && sweep_pend_r) begin
        sweep_mode_r <= 1'b1;
        sum_r        <= '0;
      end else if ((state_r == S_IDLE) && accept) begin
        sweep_mode_r <= 1'b0;
        if (home_ok) begin
          valid_cnt_r <= valid_cnt_r + COUNT_W'(1);
        end else begin
          invalid_cnt_r <= invalid_cnt_r + COUNT_W'(1);
        end
      end else if (rd_ok_r && sweep_mode_r) begin
        sum_r <= sum_r + PW'(rd_data_r);
      end else if ((state_r == S_DECIDE) && !full) begin
        sum_r <= sum_r + PW'(1);
        if (fill_inc > peak_r) begin
          peak_r <= fill_inc;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_first_r <= (state_r == S_SCAN) && (d_r == '0);
    rd_addr_r  <= raddr;

    // running minimum, strictly lower wins
    if (rd_ok_r && !sweep_mode_r && (rd_first_r || (rd_data_r < best_fill_r))) begin
      best_r      <= rd_addr_r;
      best_fill_r <= rd_data_r;
    end

    if ((state_r == S_IDLE) && accept) begin
      home_r       <= AW'(in_home_bucket);
      res_status_r <= home_ok ? STAT_PLACED : STAT_BAD_HOME;
      res_chosen_r <= '0;
      res_fill_r   <= '0;
    end else if (state_r == S_DECIDE) begin
      if (full) begin
        res_status_r <= STAT_FULL;
      end else begin
        res_status_r <= STAT_PLACED;
        res_chosen_r <= best_r;
        res_fill_r   <= fill_inc;
      end
    end

    if (state_r == S_CALC) begin
      prod_r <= PW'(n_used) * PW'(peak_r);
    end

    // result registers
    if (state_r == S_OUT) begin
      out_status        <= res_status_r;
      out_chosen_bucket <= CHOSEN_W'(res_chosen_r);
      out_new_fill      <= FILL_OUT_W'(res_fill_r);
      out_highest_fill  <= FILL_OUT_W'(peak_r);
      out_valid_total   <= valid_cnt_r;
      out_invalid_total <= invalid_cnt_r;
      out_wasted_total  <= waste;
    end
  end

  // Assertions
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SWEEP) |-> !mem_we)
    else $error("fill write during window or sum read");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_PLACED)) |->
      ((out_chosen_bucket == '0) && (out_new_fill == '0)))
    else $error("unplaced item reports a bucket");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (peak_r >= $past(peak_r)))
    else $error("highest fill decreased");

endmodule

`default_nettype wire
